// File: sv/pee_pkg.sv
// Shared types, constants and the control store for the postfix evaluator.
// No dependencies; the top-level evaluator imports this package.
package pee_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 8;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // ASCII codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_DIVZERO   = 2'd2,
      ERR_OVERFLOW  = 2'd3
   } err_type;

   // Datapath action of one microstep
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH,
      ACT_CHECK_OPS,
      ACT_ALU,
      ACT_DIV_STEP,
      ACT_DIV_WRITE,
      ACT_EMIT
   } act_type;

   // Sequencing of one microstep
   typedef enum logic [2:0] {
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_IF_SHORT,
      JMP_IF_DIV,
      JMP_DIV_LOOP,
      JMP_NOT_LAST,
      JMP_RSP_WAIT
   } jmp_type;

   typedef logic [2:0] upc_type;

   localparam upc_type UPC_FETCH   = 3'd0;
   localparam upc_type UPC_PUSH    = 3'd1;
   localparam upc_type UPC_OPRD    = 3'd2;
   localparam upc_type UPC_OPEX    = 3'd3;
   localparam upc_type UPC_DIVSTEP = 3'd4;
   localparam upc_type UPC_DIVWR   = 3'd5;
   localparam upc_type UPC_END     = 3'd6;
   localparam upc_type UPC_EMIT    = 3'd7;

   typedef struct packed {
      logic    accept;
      act_type act;
      jmp_type jmp;
      upc_type target;
   } uword_type;

   // Control store
   function automatic uword_type ucode(input upc_type upc);
      uword_type w;
      case (upc)
         UPC_FETCH:   w = '{1'b1, ACT_NONE,      JMP_DISPATCH, UPC_FETCH};
         UPC_PUSH:    w = '{1'b0, ACT_PUSH,      JMP_GOTO,     UPC_END};
         UPC_OPRD:    w = '{1'b0, ACT_CHECK_OPS, JMP_IF_SHORT, UPC_OPEX};
         UPC_OPEX:    w = '{1'b0, ACT_ALU,       JMP_IF_DIV,   UPC_DIVSTEP};
         UPC_DIVSTEP: w = '{1'b0, ACT_DIV_STEP,  JMP_DIV_LOOP, UPC_DIVWR};
         UPC_DIVWR:   w = '{1'b0, ACT_DIV_WRITE, JMP_GOTO,     UPC_END};
         UPC_END:     w = '{1'b0, ACT_NONE,      JMP_NOT_LAST, UPC_EMIT};
         UPC_EMIT:    w = '{1'b0, ACT_EMIT,      JMP_RSP_WAIT, UPC_FETCH};
         default:     w = '{1'b1, ACT_NONE,      JMP_DISPATCH, UPC_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic is_op(input logic [7:0] ch);
      return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
   endfunction

   // First error of an expression sticks
   function automatic err_type keep_first(input err_type cur, input err_type code);
      return (cur == ERR_NONE) ? code : cur;
   endfunction

endpackage

// File: sv/pee_if.sv
// Valid/ready channel interfaces for the postfix evaluator.
// Request carries one character, response one result; no dependencies.
interface pee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pee_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] value;
   logic [1:0]        error;

   modport source (output valid, output value, output error, input ready);
   modport sink   (input valid, input value, input error, output ready);
endinterface

// File: sv/postfix_expression_evaluator.sv
// Postfix expression evaluator, top level: microcoded sequencer and datapath.
// Depends on pee_pkg, pee_req_if / pee_rsp_if and pee_ram.
//
// Usage
//   req_if: one ASCII character per transfer (symbol), last marks the final
//   character of an expression. Digits push 0..9, + - * / pop two operands
//   (right first) and push the 8-bit wrapped result; other characters are
//   ignored. rsp_if: one transfer per expression, after its last character:
//   value = popped top of stack, error = first error seen (0 ok, 1 underflow,
//   2 divide by zero, 3 overflow). Stack and error clear when it is loaded.
// Sequence
//   An ignored character goes from fetch to end; a digit pushes, then
//   end; an operator checks its operands (to end if short), then + - *
//   run the ALU, and / runs the ALU setup, the eight-step restoring divide
//   loop and the write-back, then end. A last character adds the emit
//   step. The single-step sequencer handles one character at a time.
//   The response register is loaded at the end of the emit step.
// Reset and stall
//   Synchronous reset empties the stack, clears the error and the response
//   valid flag and parks the sequencer at fetch. No clearing pass is needed.
//   A stalled response holds in its register while the next expression is
//   taken in; only the next emit step waits for the register to drain.
module postfix_expression_evaluator (
   input logic        clock,
   input logic        reset,
   pee_req_if.sink    req_if,
   pee_rsp_if.source  rsp_if
);

   import pee_pkg::*;

   // Sequencer
   upc_type   upc_ff, upc_in;
   uword_type uw;

   // Captured character
   logic [7:0] symbol_ff, symbol_in;
   logic       last_ff, last_in;

   // Stack control and sticky error
   logic [SP_W-1:0] sp_ff, sp_in;
   err_type         err_ff, err_in;

   // Divider
   logic                 div_neg_ff, div_neg_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] value_ff, value_in;
   err_type           error_ff, error_in;

   // Operand store
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_top;
   logic [DATA_W-1:0] rd_next;
   logic [SP_W-1:0]   sp_m1;
   logic [SP_W-1:0]   sp_m2;

   // Misc datapath
   logic                     is_div;
   logic                     rsp_block;
   logic                     short_stack;
   logic signed [DATA_W-1:0] lhs;
   logic signed [DATA_W-1:0] rhs;
   logic signed [15:0]       prod;
   logic signed [DATA_W-1:0] alu_res;
   logic [DATA_W:0]          div_shl;
   logic                     div_ge;
   logic [DATA_W-1:0]        quo_signed;

   assign uw          = ucode(upc_ff);
   assign sp_m1       = sp_ff - SP_W'(1);
   assign sp_m2       = sp_ff - SP_W'(2);
   assign is_div      = (symbol_ff == CH_SLASH);
   assign rsp_block   = rsp_valid_ff && !rsp_if.ready;
   assign short_stack = (sp_ff < SP_W'(2));

   // Reads run every cycle at the two top entries; read data is registered, so it lags sp.
   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (sp_m1[ADDR_W-1:0]),
      .rd_a_data (rd_top),
      .rd_b_addr (sp_m2[ADDR_W-1:0]),
      .rd_b_data (rd_next)
   );

   // Arithmetic: left operand is the deeper entry
   assign lhs  = signed'(rd_next);
   assign rhs  = signed'(rd_top);
   assign prod = lhs * rhs;

   always_comb begin
      case (symbol_ff)
         CH_PLUS:  alu_res = lhs + rhs;
         CH_MINUS: alu_res = lhs - rhs;
         CH_STAR:  alu_res = prod[DATA_W-1:0];
         default:  alu_res = '0;
      endcase
   end

   // Restoring divide on magnitudes; remainder stays below a nonzero divisor
   assign div_shl    = {rem_ff, quo_ff[DATA_W-1]};
   assign div_ge     = (div_shl >= {1'b0, dvs_ff});
   assign quo_signed = div_neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

   assign req_if.ready = uw.accept;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.value = value_ff;
   assign rsp_if.error = error_ff;

   // Next microstep
   always_comb begin
      case (uw.jmp)
         JMP_GOTO: begin
            upc_in = uw.target;
         end
         JMP_DISPATCH: begin
            if (!req_if.valid) begin
               upc_in = upc_ff;
            end else if (is_digit(req_if.symbol)) begin
               upc_in = UPC_PUSH;
            end else if (is_op(req_if.symbol)) begin
               upc_in = UPC_OPRD;
            end else begin
               upc_in = UPC_END;
            end
         end
         JMP_IF_SHORT: begin
            upc_in = short_stack ? UPC_END : uw.target;
         end
         JMP_IF_DIV: begin
            upc_in = is_div ? uw.target : UPC_END;
         end
         JMP_DIV_LOOP: begin
            upc_in = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) ? uw.target : upc_ff;
         end
         JMP_NOT_LAST: begin
            upc_in = last_ff ? uw.target : UPC_FETCH;
         end
         JMP_RSP_WAIT: begin
            upc_in = rsp_block ? upc_ff : uw.target;
         end
         default: begin
            upc_in = UPC_FETCH;
         end
      endcase
   end

   // Datapath actions
   always_comb begin
      symbol_in    = symbol_ff;
      last_in      = last_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      div_neg_in   = div_neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      value_in     = value_ff;
      error_in     = error_ff;
      wr_en        = 1'b0;
      wr_addr      = sp_m2[ADDR_W-1:0];
      wr_data      = alu_res;

      if (uw.accept && req_if.valid) begin
         symbol_in = req_if.symbol;
         last_in   = req_if.last;
      end

      case (uw.act)
         ACT_PUSH: begin
            if (sp_ff == SP_W'(STACK_DEPTH)) begin
               err_in = keep_first(err_ff, ERR_OVERFLOW);
            end else begin
               wr_en   = 1'b1;
               wr_addr = sp_ff[ADDR_W-1:0];
               wr_data = symbol_ff - CH_ZERO;
               sp_in   = sp_ff + SP_W'(1);
            end
         end
         ACT_CHECK_OPS: begin
            if (short_stack) begin
               err_in = keep_first(err_ff, ERR_UNDERFLOW);
            end
         end
         ACT_ALU: begin
            if (is_div) begin
               div_neg_in = lhs[DATA_W-1] ^ rhs[DATA_W-1];
               quo_in     = lhs[DATA_W-1] ? (~rd_next + DATA_W'(1)) : rd_next;
               dvs_in     = rhs[DATA_W-1] ? (~rd_top + DATA_W'(1)) : rd_top;
               rem_in     = '0;
               cnt_in     = '0;
            end else begin
               wr_en = 1'b1;
               sp_in = sp_m1;
            end
         end
         ACT_DIV_STEP: begin
            quo_in = {quo_ff[DATA_W-2:0], div_ge};
            rem_in = div_ge ? (div_shl[DATA_W-1:0] - dvs_ff) : div_shl[DATA_W-1:0];
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ACT_DIV_WRITE: begin
            wr_en = 1'b1;
            sp_in = sp_m1;
            if (dvs_ff == '0) begin
               err_in  = keep_first(err_ff, ERR_DIVZERO);
               wr_data = '0;
            end else begin
               wr_data = quo_signed;
            end
         end
         ACT_EMIT: begin
            if (!rsp_block) begin
               rsp_valid_in = 1'b1;
               if (sp_ff == '0) begin
                  value_in = '0;
                  error_in = keep_first(err_ff, ERR_UNDERFLOW);
               end else begin
                  value_in = signed'(rd_top);
                  error_in = err_ff;
               end
               sp_in  = '0;
               err_in = ERR_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_FETCH;
         sp_ff        <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff  <= symbol_in;
      last_ff    <= last_in;
      div_neg_ff <= div_neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      value_ff   <= value_in;
      error_ff   <= error_in;
   end

   // Checks
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_EMIT && !rsp_block) |=>
         (sp_ff == '0 && err_ff == ERR_NONE && rsp_valid_ff && upc_ff == UPC_FETCH))
      else $error("emit did not load response and clear stack");

   a_div_full_loop: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_DIVWR) |->
         ($past(upc_ff) == UPC_DIVSTEP && $past(cnt_ff) == DIV_CNT_W'(DIV_STEPS - 1)))
      else $error("divide wrote back before all quotient bits");

endmodule

// File: sv/pee_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module pee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
